// ===== design/tdlc_pkg.sv =====
`default_nettype none

package tdlc_pkg;

   // result field widths
   localparam int STATUS_W      = 4;
   localparam int TYPE_CODE_W   = 4;
   localparam int NAME_START_W  = 10;
   localparam int NAME_LENGTH_W = 11;
   localparam int VALUE_START_W = 10;
   localparam int VALUE_LENGTH_W = 11;
   localparam int LINE_W        = 16;

   // token text keeps its first seven bytes, first byte in the low lane
   localparam int PREFIX_W = 56;
   localparam int FLAGS_W  = 5;
   localparam int TOK_IDX_W = 3;

   typedef enum logic [2:0] {
      LX_IDLE,
      LX_WORD,
      LX_NUM,
      LX_SYM,
      LX_STR,
      LX_HALT
   } lexer_mode_type;

   // token slots within a line
   localparam logic [TOK_IDX_W-1:0] TOK_TYPE  = 3'd0;
   localparam logic [TOK_IDX_W-1:0] TOK_NAME  = 3'd1;
   localparam logic [TOK_IDX_W-1:0] TOK_COLON = 3'd2;
   localparam logic [TOK_IDX_W-1:0] TOK_VALUE = 3'd3;
   localparam logic [TOK_IDX_W-1:0] TOK_FULL  = 3'd4;
   localparam logic [TOK_IDX_W-1:0] TOK_MAX   = 3'd7;

   // number token flags
   localparam logic [FLAGS_W-1:0] FL_FIRST_MINUS = 5'b00001;
   localparam logic [FLAGS_W-1:0] FL_FIRST_DOT   = 5'b00010;
   localparam logic [FLAGS_W-1:0] FL_LATER_MINUS = 5'b00100;
   localparam logic [FLAGS_W-1:0] FL_DOT         = 5'b01000;
   localparam logic [FLAGS_W-1:0] FL_TWO_DOTS    = 5'b10000;

   localparam logic [STATUS_W-1:0] ST_OK        = 4'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_CHAR  = 4'd1;
   localparam logic [STATUS_W-1:0] ST_UNCLOSED  = 4'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_TYPE  = 4'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_NAME  = 4'd4;
   localparam logic [STATUS_W-1:0] ST_NO_COLON  = 4'd5;
   localparam logic [STATUS_W-1:0] ST_EXTRA     = 4'd6;
   localparam logic [STATUS_W-1:0] ST_MISMATCH  = 4'd7;
   localparam logic [STATUS_W-1:0] ST_FEW_TOKENS = 4'd8;
   localparam logic [STATUS_W-1:0] ST_LONG      = 4'd9;

   localparam logic [TYPE_CODE_W-1:0] TC_NONE     = 4'd0;
   localparam logic [TYPE_CODE_W-1:0] TC_LAST_INT = 4'd4;
   localparam logic [TYPE_CODE_W-1:0] TC_LAST_UNS = 4'd8;
   localparam logic [TYPE_CODE_W-1:0] TC_LAST_REAL = 4'd10;
   localparam logic [TYPE_CODE_W-1:0] TC_STRING   = 4'd11;

   typedef struct packed {
      lexer_mode_type                lx;
      logic [TOK_IDX_W-1:0]          tok_idx;
      logic [PREFIX_W-1:0]           cur_chars;
      logic [FLAGS_W-1:0]            cur_flags;
      logic [PREFIX_W-1:0]           type_chars;
      logic [PREFIX_W-1:0]           name_chars;
      lexer_mode_type                name_class;
      lexer_mode_type                colon_class;
      lexer_mode_type                value_class;
      logic [FLAGS_W-1:0]            value_flags;
      logic [STATUS_W-1:0]           line_err;
   } lex_state_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [TYPE_CODE_W-1:0]    type_code;
      logic [NAME_START_W-1:0]   name_start;
      logic [NAME_LENGTH_W-1:0]  name_length;
      logic [VALUE_START_W-1:0]  value_start;
      logic [VALUE_LENGTH_W-1:0] value_length;
   } rsp_fields_type;

endpackage

`default_nettype wire

// ===== design/tdlc_line_eval.sv =====
`default_nettype none

// End-of-line evaluation: closes the open token, then checks the line.
module tdlc_line_eval
   import tdlc_pkg::*;
#(
   parameter int POS_W = 11
) (
   input  lex_state_type  st,
   input  logic [POS_W-1:0] tok_start,
   input  logic [POS_W-1:0] line_pos,
   input  logic [POS_W-1:0] type_len,
   input  logic [POS_W-1:0] name_start,
   input  logic [POS_W-1:0] name_len,
   input  logic [POS_W-1:0] value_start,
   input  logic [POS_W-1:0] value_len,
   output logic           has_result,
   output rsp_fields_type fields
);

   localparam int NUM_TYPES = 11;

   localparam logic [PREFIX_W-1:0] TYPE_WORD [NUM_TYPES] = '{
      56'h3869,   56'h363169, 56'h323369, 56'h343669,
      56'h3875,   56'h363175, 56'h323375, 56'h343675,
      56'h323366, 56'h343666, 56'h676e69727473
   };
   localparam logic [2:0] TYPE_LEN [NUM_TYPES] = '{
      3'd2, 3'd3, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd6
   };

   function automatic logic [TYPE_CODE_W-1:0] lookup_type(
      input logic [PREFIX_W-1:0] chars,
      input logic [2:0]          len
   );
      logic [TYPE_CODE_W-1:0] code;
      code = TC_NONE;
      for (int k = 0; k < NUM_TYPES; k++) begin
         if (len == TYPE_LEN[k] && chars == TYPE_WORD[k]) begin
            code = TYPE_CODE_W'(k + 1);
         end
      end
      return code;
   endfunction

   // lengths of seven and up never match a type word
   function automatic logic [2:0] clamp_len(input logic [POS_W-1:0] len);
      return (len > POS_W'(6)) ? 3'd7 : 3'(len);
   endfunction

   logic                   open_tok;
   logic [TOK_IDX_W-1:0]   tok_cnt;
   logic [POS_W-1:0]       end_len;
   logic [PREFIX_W-1:0]    type_chars_e;
   logic [POS_W-1:0]       type_len_e;
   logic [PREFIX_W-1:0]    name_chars_e;
   lexer_mode_type         name_class_e;
   logic [POS_W-1:0]       name_start_e;
   logic [POS_W-1:0]       name_len_e;
   lexer_mode_type         colon_class_e;
   lexer_mode_type         value_class_e;
   logic [FLAGS_W-1:0]     value_flags_e;
   logic [POS_W-1:0]       value_start_e;
   logic [POS_W-1:0]       value_len_e;
   logic [TYPE_CODE_W-1:0] code;
   logic [TYPE_CODE_W-1:0] name_code;
   logic                   is_num;
   logic                   int_ok;
   logic                   real_ok;
   logic [STATUS_W-1:0]    value_status;
   logic [STATUS_W-1:0]    status;

   always_comb begin
      open_tok = (st.lx != LX_IDLE);
      end_len  = line_pos - tok_start;
      tok_cnt  = (open_tok && st.tok_idx != TOK_MAX) ? st.tok_idx + 3'd1 : st.tok_idx;

      type_chars_e  = st.type_chars;
      type_len_e    = type_len;
      name_chars_e  = st.name_chars;
      name_class_e  = st.name_class;
      name_start_e  = name_start;
      name_len_e    = name_len;
      colon_class_e = st.colon_class;
      value_class_e = st.value_class;
      value_flags_e = st.value_flags;
      value_start_e = value_start;
      value_len_e   = value_len;
      if (open_tok) begin
         case (st.tok_idx)
            TOK_TYPE: begin
               type_chars_e = st.cur_chars;
               type_len_e   = end_len;
            end
            TOK_NAME: begin
               name_chars_e = st.cur_chars;
               name_class_e = st.lx;
               name_start_e = tok_start;
               name_len_e   = end_len;
            end
            TOK_COLON: begin
               colon_class_e = st.lx;
            end
            TOK_VALUE: begin
               value_class_e = st.lx;
               value_flags_e = st.cur_flags;
               value_start_e = tok_start;
               value_len_e   = end_len;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      code      = lookup_type(type_chars_e, clamp_len(type_len_e));
      name_code = lookup_type(name_chars_e, clamp_len(name_len_e));

      is_num  = (value_class_e == LX_NUM);
      int_ok  = is_num && ((value_flags_e & (FL_FIRST_DOT | FL_LATER_MINUS | FL_DOT)) == '0);
      real_ok = is_num && ((value_flags_e & (FL_FIRST_MINUS | FL_FIRST_DOT | FL_LATER_MINUS
                                             | FL_TWO_DOTS)) == '0);
      if (code <= TC_LAST_INT) begin
         value_status = int_ok ? ST_OK : ST_MISMATCH;
      end else if (code <= TC_LAST_UNS) begin
         value_status = (int_ok && ((value_flags_e & FL_FIRST_MINUS) == '0))
                      ? ST_OK : ST_MISMATCH;
      end else if (code <= TC_LAST_REAL) begin
         value_status = real_ok ? ST_OK : ST_MISMATCH;
      end else begin
         value_status = (value_class_e == LX_STR) ? ST_OK : ST_MISMATCH;
      end

      if (st.line_err == ST_LONG) begin
         status = ST_LONG;
      end else if (st.line_err == ST_BAD_CHAR) begin
         status = ST_BAD_CHAR;
      end else if (st.lx == LX_STR) begin
         status = ST_UNCLOSED;
      end else if (tok_cnt < TOK_FULL) begin
         status = ST_FEW_TOKENS;
      end else if (code == TC_NONE) begin
         status = ST_BAD_TYPE;
      end else if (name_class_e != LX_WORD || name_code != TC_NONE) begin
         status = ST_BAD_NAME;
      end else if (colon_class_e != LX_SYM) begin
         status = ST_NO_COLON;
      end else if (tok_cnt > TOK_FULL) begin
         status = ST_EXTRA;
      end else begin
         status = value_status;
      end
   end

   always_comb begin
      has_result = (line_pos != '0) || (st.line_err != ST_OK);
      fields = '0;
      fields.status = status;
      if (status == ST_OK || status == ST_BAD_NAME || status == ST_NO_COLON
          || status == ST_EXTRA || status == ST_MISMATCH) begin
         fields.type_code = code;
      end
      if (status == ST_OK || status == ST_NO_COLON || status == ST_EXTRA
          || status == ST_MISMATCH) begin
         fields.name_start  = NAME_START_W'(name_start_e);
         fields.name_length = NAME_LENGTH_W'(name_len_e);
      end
      if (status == ST_OK) begin
         fields.value_start  = VALUE_START_W'(value_start_e);
         fields.value_length = VALUE_LENGTH_W'(value_len_e);
         // strip the quotes
         if (code == TC_STRING) begin
            fields.value_start  = VALUE_START_W'(value_start_e) + VALUE_START_W'(1);
            fields.value_length = VALUE_LENGTH_W'(value_len_e) - VALUE_LENGTH_W'(2);
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/typed_declaration_line_checker_core.sv =====
`default_nettype none

// Channel  Dir  Handshake              Word
// req      in   req_valid/req_ready    req_char_byte, req_end_of_stream
// rsp      out  rsp_valid/rsp_ready    rsp_status .. rsp_line_number
//
// One byte per cycle sustained while results are taken; a byte is lexed from the
// input register, and a newline or last byte there loads the line's word.
// The input register and the result register each hold one word; the input
// register drains whenever the result register is empty or being taken.
// Reset is synchronous; it empties both registers and sets the line count to 1.
// The flagged last byte also returns all line state and the line count to reset.
module typed_declaration_line_checker_core
   import tdlc_pkg::*;
#(
   parameter int MAX_LINE         = 1024,
   parameter int LINE_NUMBER_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_char_byte,
   input  logic                      req_end_of_stream,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [TYPE_CODE_W-1:0]    rsp_type_code,
   output logic [NAME_START_W-1:0]   rsp_name_start,
   output logic [NAME_LENGTH_W-1:0]  rsp_name_length,
   output logic [VALUE_START_W-1:0]  rsp_value_start,
   output logic [VALUE_LENGTH_W-1:0] rsp_value_length,
   output logic [LINE_W-1:0]         rsp_line_number
);

   localparam int POS_W = $clog2(MAX_LINE + 1);
   localparam logic [LINE_NUMBER_BITS-1:0] LINE_TOP = '1;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_QUOTE   = 8'h27;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_UNDER   = 8'h5F;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_num_char(input logic [7:0] c);
      return is_digit(c) || c == CH_MINUS || c == CH_DOT;
   endfunction

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eos_ff;

   // line state
   lex_state_type             st_ff, st_lx, st_in;
   logic [POS_W-1:0]          tok_start_ff, tok_start_lx;
   logic [POS_W-1:0]          line_pos_ff, line_pos_lx, line_pos_in;
   logic [POS_W-1:0]          type_len_ff, type_len_lx;
   logic [POS_W-1:0]          name_start_ff, name_start_lx;
   logic [POS_W-1:0]          name_len_ff, name_len_lx;
   logic [POS_W-1:0]          value_start_ff, value_start_lx;
   logic [POS_W-1:0]          value_len_ff, value_len_lx;
   logic [LINE_NUMBER_BITS-1:0] line_num_ff, line_num_in;

   // result register
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_fields_type rsp_fields_ff;
   logic [LINE_W-1:0] rsp_line_ff;

   logic           advance;
   logic           line_end;
   logic           has_result;
   rsp_fields_type eval_fields;

   // lexer scratch
   logic             do_add;
   logic             do_fin;
   logic             do_idle;
   logic             keep;
   logic [POS_W-1:0] fin_end;
   logic [POS_W-1:0] fin_len;
   logic [POS_W-1:0] char_ofs;
   logic [7:0]       c;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign c         = in_byte_ff;
   assign line_end  = (c == CH_NEWLINE) || in_eos_ff;

   always_comb begin
      st_lx          = st_ff;
      tok_start_lx   = tok_start_ff;
      line_pos_lx    = line_pos_ff;
      type_len_lx    = type_len_ff;
      name_start_lx  = name_start_ff;
      name_len_lx    = name_len_ff;
      value_start_lx = value_start_ff;
      value_len_lx   = value_len_ff;
      do_add   = 1'b0;
      do_fin   = 1'b0;
      do_idle  = 1'b0;
      fin_end  = line_pos_ff;
      fin_len  = '0;
      char_ofs = line_pos_ff - tok_start_ff;

      case (st_ff.lx)
         LX_WORD: keep = is_alpha(c) || is_digit(c) || c == CH_UNDER;
         LX_NUM:  keep = is_num_char(c);
         LX_SYM:  keep = (c == CH_COLON);
         default: keep = 1'b0;
      endcase

      // a newline is not lexed; once a line is too long nothing more is
      if (c != CH_NEWLINE && st_ff.line_err != ST_LONG) begin
         if (line_pos_ff >= POS_W'(MAX_LINE)) begin
            st_lx.line_err = ST_LONG;
         end else begin
            line_pos_lx = line_pos_ff + POS_W'(1);
            case (st_ff.lx)
               LX_HALT: ;
               LX_STR: begin
                  do_add = 1'b1;
                  if (c == CH_QUOTE) begin
                     do_fin  = 1'b1;
                     fin_end = line_pos_ff + POS_W'(1);
                  end
               end
               LX_WORD, LX_NUM, LX_SYM: begin
                  if (keep) begin
                     do_add = 1'b1;
                  end else begin
                     do_fin  = 1'b1;
                     do_idle = 1'b1;
                  end
               end
               default: do_idle = 1'b1;
            endcase
         end
      end

      if (do_add) begin
         if (char_ofs < POS_W'(7)) begin
            st_lx.cur_chars = st_lx.cur_chars
                            | (PREFIX_W'(c) << {char_ofs[2:0], 3'b000});
         end
         if (st_ff.lx == LX_NUM) begin
            if (c == CH_MINUS) begin
               st_lx.cur_flags = st_lx.cur_flags | FL_LATER_MINUS;
            end
            if (c == CH_DOT) begin
               if ((st_lx.cur_flags & FL_DOT) != '0) begin
                  st_lx.cur_flags = st_lx.cur_flags | FL_TWO_DOTS;
               end
               st_lx.cur_flags = st_lx.cur_flags | FL_DOT;
            end
         end
      end

      if (do_fin) begin
         fin_len = fin_end - tok_start_ff;
         case (st_ff.tok_idx)
            TOK_TYPE: begin
               st_lx.type_chars = st_lx.cur_chars;
               type_len_lx      = fin_len;
            end
            TOK_NAME: begin
               st_lx.name_chars = st_lx.cur_chars;
               st_lx.name_class = st_ff.lx;
               name_start_lx    = tok_start_ff;
               name_len_lx      = fin_len;
            end
            TOK_COLON: begin
               st_lx.colon_class = st_ff.lx;
            end
            TOK_VALUE: begin
               st_lx.value_class = st_ff.lx;
               st_lx.value_flags = st_lx.cur_flags;
               value_start_lx    = tok_start_ff;
               value_len_lx      = fin_len;
            end
            default: ;
         endcase
         if (st_ff.tok_idx != TOK_MAX) begin
            st_lx.tok_idx = st_ff.tok_idx + 3'd1;
         end
         st_lx.lx = LX_IDLE;
      end

      if (do_idle) begin
         if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
            // blank: nothing to do
         end else if (is_alpha(c) || c == CH_UNDER || is_num_char(c) || c == CH_COLON
                      || c == CH_QUOTE) begin
            tok_start_lx    = line_pos_ff;
            st_lx.cur_chars = PREFIX_W'(c);
            st_lx.cur_flags = '0;
            if (is_alpha(c) || c == CH_UNDER) begin
               st_lx.lx = LX_WORD;
            end else if (is_num_char(c)) begin
               st_lx.lx = LX_NUM;
               if (c == CH_MINUS) begin
                  st_lx.cur_flags = FL_FIRST_MINUS;
               end else if (c == CH_DOT) begin
                  st_lx.cur_flags = FL_FIRST_DOT;
               end
            end else if (c == CH_COLON) begin
               st_lx.lx = LX_SYM;
            end else begin
               st_lx.lx = LX_STR;
            end
         end else begin
            st_lx.line_err = ST_BAD_CHAR;
            st_lx.lx       = LX_HALT;
         end
      end
   end

   tdlc_line_eval #(
      .POS_W (POS_W)
   ) u_line_eval (
      .st          (st_lx),
      .tok_start   (tok_start_lx),
      .line_pos    (line_pos_lx),
      .type_len    (type_len_lx),
      .name_start  (name_start_lx),
      .name_len    (name_len_lx),
      .value_start (value_start_lx),
      .value_len   (value_len_lx),
      .has_result  (has_result),
      .fields      (eval_fields)
   );

   always_comb begin
      st_in       = st_lx;
      line_pos_in = line_pos_lx;
      line_num_in = line_num_ff;
      if (line_end) begin
         st_in       = '0;
         line_pos_in = '0;
         if (in_eos_ff) begin
            line_num_in = LINE_NUMBER_BITS'(1);
         end else if (line_num_ff != LINE_TOP) begin
            line_num_in = line_num_ff + LINE_NUMBER_BITS'(1);
         end
      end

      if (advance && line_end && has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= '0;
         line_pos_ff  <= '0;
         line_num_ff  <= LINE_NUMBER_BITS'(1);
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            st_ff       <= st_in;
            line_pos_ff <= line_pos_in;
            line_num_ff <= line_num_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_char_byte;
         in_eos_ff  <= req_end_of_stream;
      end
      if (advance) begin
         tok_start_ff   <= tok_start_lx;
         type_len_ff    <= type_len_lx;
         name_start_ff  <= name_start_lx;
         name_len_ff    <= name_len_lx;
         value_start_ff <= value_start_lx;
         value_len_ff   <= value_len_lx;
      end
      if (advance && line_end && has_result) begin
         rsp_fields_ff <= eval_fields;
         rsp_line_ff   <= LINE_W'(line_num_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_fields_ff.status;
   assign rsp_type_code    = rsp_fields_ff.type_code;
   assign rsp_name_start   = rsp_fields_ff.name_start;
   assign rsp_name_length  = rsp_fields_ff.name_length;
   assign rsp_value_start  = rsp_fields_ff.value_start;
   assign rsp_value_length = rsp_fields_ff.value_length;
   assign rsp_line_number  = rsp_line_ff;

endmodule

`default_nettype wire

// ===== design/tdlc_checker.sv =====
`default_nettype none

module tdlc_checker
   import tdlc_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic [STATUS_W-1:0]       rsp_status,
   input wire logic [TYPE_CODE_W-1:0]    rsp_type_code,
   input wire logic [NAME_START_W-1:0]   rsp_name_start,
   input wire logic [NAME_LENGTH_W-1:0]  rsp_name_length,
   input wire logic [VALUE_START_W-1:0]  rsp_value_start,
   input wire logic [VALUE_LENGTH_W-1:0] rsp_value_length,
   input wire logic [LINE_W-1:0]         rsp_line_number
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_line_number) && $stable(rsp_name_start))
      else $error("rsp word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // lines that fail before the type is known carry no type and no positions
   a_early_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BAD_CHAR || rsp_status == ST_UNCLOSED
         || rsp_status == ST_BAD_TYPE || rsp_status == ST_FEW_TOKENS
         || rsp_status == ST_LONG)
      |-> rsp_type_code == TC_NONE && rsp_name_length == '0 && rsp_name_start == '0)
      else $error("early failure carries fields");

   a_ok_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK
      |-> rsp_type_code != TC_NONE && rsp_type_code <= TC_STRING && rsp_name_length != '0)
      else $error("ok word without type or name");

   a_value_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_value_start == '0 && rsp_value_length == '0)
      else $error("value position on a failed line");

endmodule

bind typed_declaration_line_checker_core tdlc_checker u_tdlc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_type_code    (rsp_type_code),
   .rsp_name_start   (rsp_name_start),
   .rsp_name_length  (rsp_name_length),
   .rsp_value_start  (rsp_value_start),
   .rsp_value_length (rsp_value_length),
   .rsp_line_number  (rsp_line_number)
);

`default_nettype wire

// ===== tb/tb_typed_declaration_line_checker_core.sv =====
`default_nettype none

module tb_typed_declaration_line_checker_core;
   import tdlc_pkg::*;

   localparam int LINE_LIMIT = 1024;
   localparam int LINE_TOP = 65535;
   localparam int CYCLE_LIMIT = 600000;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF = 8'h0a;
   localparam logic [7:0] CH_CR = 8'h0d;

   typedef struct packed {
      rsp_fields_type f;
      logic [LINE_W-1:0] line_no;
   } decl_result_type;

   class decl_scoreboard;
      string type_words[11] = '{"i8", "i16", "i32", "i64", "u8", "u16", "u32", "u64",
                                "f32", "f64", "string"};
      lexer_mode_type mode, name_class, colon_class, value_class;
      int unsigned tok_count, tok_start, line_pos, type_len;
      int unsigned name_start, name_len, value_start, value_len, line_count;
      logic [PREFIX_W-1:0] cur_chars, type_chars, name_chars;
      logic [FLAGS_W-1:0] cur_flags, value_flags;
      logic [STATUS_W-1:0] line_err;
      decl_result_type pending[$];
      int errors;
      int lines_out;

      function new();
         clear_line();
         line_count = 1;
         errors = 0;
         lines_out = 0;
      endfunction

      function void clear_line();
         mode = LX_IDLE;
         name_class = LX_IDLE;
         colon_class = LX_IDLE;
         value_class = LX_IDLE;
         tok_count = 0;
         tok_start = 0;
         line_pos = 0;
         type_len = 0;
         name_start = 0;
         name_len = 0;
         value_start = 0;
         value_len = 0;
         cur_chars = '0;
         type_chars = '0;
         name_chars = '0;
         cur_flags = '0;
         value_flags = '0;
         line_err = ST_OK;
      endfunction

      function bit is_alpha(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      // exact match on length and on the kept prefix bytes
      function logic [TYPE_CODE_W-1:0] type_code_of(logic [PREFIX_W-1:0] chars,
                                                    int unsigned len);
         logic [PREFIX_W-1:0] word_bits;
         for (int k = 0; k < 11; k++) begin
            word_bits = '0;
            for (int n = 0; n < type_words[k].len(); n++)
               word_bits[8*n +: 8] = type_words[k][n];
            if (type_words[k].len() == len && word_bits == chars)
               return TYPE_CODE_W'(k + 1);
         end
         return TC_NONE;
      endfunction

      function void add_char(logic [7:0] c, int unsigned pos);
         int unsigned k;
         k = pos - tok_start;
         if (k < 7)
            cur_chars[8*k +: 8] = c;
         if (mode == LX_NUM) begin
            if (c == "-")
               cur_flags |= FL_LATER_MINUS;
            if (c == ".") begin
               if ((cur_flags & FL_DOT) != 0)
                  cur_flags |= FL_TWO_DOTS;
               cur_flags |= FL_DOT;
            end
         end
      endfunction

      function void close_token(int unsigned end_pos);
         int unsigned len;
         len = end_pos - tok_start;
         case (tok_count)
            TOK_TYPE: begin
               type_chars = cur_chars;
               type_len = len;
            end
            TOK_NAME: begin
               name_chars = cur_chars;
               name_class = mode;
               name_start = tok_start;
               name_len = len;
            end
            TOK_COLON: colon_class = mode;
            TOK_VALUE: begin
               value_class = mode;
               value_flags = cur_flags;
               value_start = tok_start;
               value_len = len;
            end
            default: ;
         endcase
         if (tok_count < TOK_MAX)
            tok_count++;
         mode = LX_IDLE;
      endfunction

      function void open_token(lexer_mode_type kind, logic [7:0] c, int unsigned pos);
         mode = kind;
         tok_start = pos;
         cur_chars = PREFIX_W'(c);
         cur_flags = '0;
         if (kind == LX_NUM) begin
            if (c == "-")
               cur_flags = FL_FIRST_MINUS;
            else if (c == ".")
               cur_flags = FL_FIRST_DOT;
         end
      endfunction

      function void idle_byte(logic [7:0] c, int unsigned pos);
         if (c == " " || c == CH_TAB || c == CH_CR)
            return;
         if (is_alpha(c) || c == "_")
            open_token(LX_WORD, c, pos);
         else if (is_digit(c) || c == "-" || c == ".")
            open_token(LX_NUM, c, pos);
         else if (c == ":")
            open_token(LX_SYM, c, pos);
         else if (c == "'")
            open_token(LX_STR, c, pos);
         else begin
            line_err = ST_BAD_CHAR;
            mode = LX_HALT;
         end
      endfunction

      function void end_line();
         logic [STATUS_W-1:0] st;
         logic [TYPE_CODE_W-1:0] code;
         decl_result_type r;
         bit num, int_ok;
         int unsigned vs, vl;
         st = ST_OK;
         code = TC_NONE;
         if (line_pos != 0 || line_err != ST_OK) begin
            if (line_err == ST_LONG)
               st = ST_LONG;
            else if (line_err == ST_BAD_CHAR)
               st = ST_BAD_CHAR;
            else if (mode == LX_STR)
               st = ST_UNCLOSED;
            else begin
               if (mode != LX_IDLE)
                  close_token(line_pos);
               if (tok_count < TOK_FULL)
                  st = ST_FEW_TOKENS;
               else begin
                  code = type_code_of(type_chars, type_len);
                  num = value_class == LX_NUM;
                  int_ok = num && (value_flags & (FL_FIRST_DOT | FL_LATER_MINUS | FL_DOT)) == 0;
                  if (code == TC_NONE)
                     st = ST_BAD_TYPE;
                  else if (name_class != LX_WORD || type_code_of(name_chars, name_len) != TC_NONE)
                     st = ST_BAD_NAME;
                  else if (colon_class != LX_SYM)
                     st = ST_NO_COLON;
                  else if (tok_count > TOK_FULL)
                     st = ST_EXTRA;
                  else if (code <= TC_LAST_INT)
                     st = int_ok ? ST_OK : ST_MISMATCH;
                  else if (code <= TC_LAST_UNS)
                     st = (int_ok && (value_flags & FL_FIRST_MINUS) == 0) ? ST_OK : ST_MISMATCH;
                  else if (code <= TC_LAST_REAL)
                     st = (num && (value_flags & (FL_FIRST_MINUS | FL_FIRST_DOT | FL_LATER_MINUS
                                                  | FL_TWO_DOTS)) == 0) ? ST_OK : ST_MISMATCH;
                  else
                     st = (value_class == LX_STR) ? ST_OK : ST_MISMATCH;
               end
            end
            r = '0;
            r.f.status = st;
            if (st == ST_OK || (st >= ST_BAD_NAME && st <= ST_MISMATCH))
               r.f.type_code = code;
            if (st == ST_OK || (st >= ST_NO_COLON && st <= ST_MISMATCH)) begin
               r.f.name_start = NAME_START_W'(name_start);
               r.f.name_length = NAME_LENGTH_W'(name_len);
            end
            if (st == ST_OK) begin
               vs = value_start;
               vl = value_len;
               // quotes are not part of a string value
               if (code == TC_STRING) begin
                  vs += 1;
                  vl -= 2;
               end
               r.f.value_start = VALUE_START_W'(vs);
               r.f.value_length = VALUE_LENGTH_W'(vl);
            end
            r.line_no = LINE_W'(line_count);
            pending.push_back(r);
            lines_out++;
         end
         if (line_count < LINE_TOP)
            line_count++;
         clear_line();
      endfunction

      function void note_byte(logic [7:0] c, logic eos);
         int unsigned pos;
         bit keep;
         if (c != CH_LF && line_err != ST_LONG) begin
            if (line_pos >= LINE_LIMIT)
               line_err = ST_LONG;
            else begin
               pos = line_pos;
               line_pos++;
               case (mode)
                  LX_HALT: ;
                  LX_STR: begin
                     add_char(c, pos);
                     if (c == "'")
                        close_token(pos + 1);
                  end
                  LX_WORD, LX_NUM, LX_SYM: begin
                     if (mode == LX_WORD)
                        keep = is_alpha(c) || is_digit(c) || c == "_";
                     else if (mode == LX_NUM)
                        keep = is_digit(c) || c == "-" || c == ".";
                     else
                        keep = c == ":";
                     if (keep)
                        add_char(c, pos);
                     else begin
                        close_token(pos);
                        idle_byte(c, pos);
                     end
                  end
                  default: idle_byte(c, pos);
               endcase
            end
         end
         if (c == CH_LF || eos)
            end_line();
         // last byte of the text: everything back to reset
         if (eos) begin
            clear_line();
            line_count = 1;
         end
      endfunction

      function string describe(decl_result_type r);
         return $sformatf("status %0d type %0d name %0d+%0d value %0d+%0d line %0d",
                          r.f.status, r.f.type_code, r.f.name_start, r.f.name_length,
                          r.f.value_start, r.f.value_length, r.line_no);
      endfunction

      function void check_result(decl_result_type got);
         decl_result_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("result word with none pending: %s", describe(got));
            return;
         end
         want = pending.pop_front();
         if (got.f.status !== want.f.status || got.f.type_code !== want.f.type_code
             || got.f.name_start !== want.f.name_start
             || got.f.name_length !== want.f.name_length
             || got.f.value_start !== want.f.value_start
             || got.f.value_length !== want.f.value_length
             || got.line_no !== want.line_no) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected %s, got %s", describe(want), describe(got));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_char_byte = 8'h00;
   logic req_end_of_stream = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [TYPE_CODE_W-1:0] rsp_type_code;
   logic [NAME_START_W-1:0] rsp_name_start;
   logic [NAME_LENGTH_W-1:0] rsp_name_length;
   logic [VALUE_START_W-1:0] rsp_value_start;
   logic [VALUE_LENGTH_W-1:0] rsp_value_length;
   logic [LINE_W-1:0] rsp_line_number;

   decl_scoreboard sb = new();
   logic [7:0] text_q[$];
   bit calm = 1'b0;
   int cycles = 0;
   int hold_cnt = 0;

   typed_declaration_line_checker_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_char_byte(req_char_byte),
      .req_end_of_stream(req_end_of_stream),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_type_code(rsp_type_code),
      .rsp_name_start(rsp_name_start),
      .rsp_name_length(rsp_name_length),
      .rsp_value_start(rsp_value_start),
      .rsp_value_length(rsp_value_length),
      .rsp_line_number(rsp_line_number)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int gap_len();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 30);
   endfunction

   // result side: check taken words, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_result({rsp_status, rsp_type_code, rsp_name_start, rsp_name_length,
                             rsp_value_start, rsp_value_length, rsp_line_number});
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
               hold_cnt = gap_len();
         end
      end
   end

   task automatic send_byte(logic [7:0] c, logic eos);
      req_valid <= 1'b1;
      req_char_byte <= c;
      req_end_of_stream <= eos;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(c, eos);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
   endtask

   task automatic send_text(bit eos);
      for (int i = 0; i < text_q.size(); i++)
         send_byte(text_q[i], eos && i == text_q.size() - 1);
      text_q.delete();
   endtask

   // request side goes idle while the last words come back
   task automatic wait_drained();
      if (sb.pending.size() != 0) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (sb.pending.size() != 0);
      end
   endtask

   function automatic void put_str(string s);
      for (int i = 0; i < s.len(); i++)
         text_q.push_back(s[i]);
   endfunction

   function automatic void put_blanks(int most);
      int r;
      repeat ($urandom_range(0, most)) begin
         r = $urandom_range(0, 5);
         text_q.push_back(r == 0 ? CH_TAB : r == 1 ? CH_CR : 8'h20);
      end
   endfunction

   function automatic void put_word(int lo, int hi);
      string alnum;
      alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
      text_q.push_back(alnum[$urandom_range(0, 52)]);
      repeat ($urandom_range(lo, hi))
         text_q.push_back(alnum[$urandom_range(0, 62)]);
   endfunction

   function automatic void put_digits(int lo, int hi);
      repeat ($urandom_range(lo, hi))
         text_q.push_back(8'($urandom_range("0", "9")));
   endfunction

   // cls: 0 signed int, 1 unsigned, 2 real, 3 string, else a word
   function automatic void put_value(int cls);
      case (cls)
         0, 1: begin
            if ($urandom_range(0, 2) == 0)
               put_str("-");
            put_digits($urandom_range(0, 9) == 0 ? 0 : 1, 6);
            if ($urandom_range(0, 9) == 0) begin
               put_str($urandom_range(0, 1) ? "-" : ".");
               put_digits(0, 2);
            end
         end
         2: begin
            if ($urandom_range(0, 9) == 0)
               put_str($urandom_range(0, 1) ? "-" : ".");
            put_digits(1, 5);
            if ($urandom_range(0, 9) < 7) begin
               put_str(".");
               put_digits(0, 4);
               if ($urandom_range(0, 9) == 0)
                  put_str(".");
            end
         end
         3: begin
            put_str("'");
            repeat ($urandom_range(0, 8))
               text_q.push_back(8'($urandom_range(8'h20, 8'h26)) + ($urandom_range(0, 1) ? 8'h00
                                                                                    : 8'h30));
            if ($urandom_range(0, 19) != 0)
               put_str("'");
         end
         default: put_word(0, 5);
      endcase
   endfunction

   function automatic void make_line();
      int t, cls;
      string sym;
      sym = " :'-._a9";
      if ($urandom_range(0, 99) < 15) begin
         repeat ($urandom_range(0, 16))
            text_q.push_back($urandom_range(0, 3) == 0 ? sym[$urandom_range(0, 7)]
                                                       : 8'($urandom_range(0, 255)));
         return;
      end
      put_blanks(1);
      t = $urandom_range(0, 10);
      if ($urandom_range(0, 19) == 0)
         put_word(0, 6);
      else
         put_str(sb.type_words[t]);
      put_str(" ");
      put_blanks(1);
      case ($urandom_range(0, 19))
         0: put_str(sb.type_words[$urandom_range(0, 10)]);
         1: put_digits(1, 3);
         default: put_word(0, 8);
      endcase
      put_blanks(2);
      if ($urandom_range(0, 9) != 0) begin
         repeat ($urandom_range(1, 3))
            put_str(":");
      end
      put_blanks(2);
      if ($urandom_range(0, 99) < 85)
         cls = t < 4 ? 0 : t < 8 ? 1 : t < 10 ? 2 : 3;
      else
         cls = $urandom_range(0, 4);
      if ($urandom_range(0, 19) != 0)
         put_value(cls);
      if ($urandom_range(0, 19) == 0) begin
         put_str(" ");
         put_value($urandom_range(0, 4));
      end
      put_blanks(1);
   endfunction

   initial begin
      int rand_bytes, first_lines, r;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      put_str("i8 x : 0\n");
      put_str("i16 v1 : -123\n");
      put_str("i32 a_b::: -\n");
      put_str("i64 _Z9 : 12-3\n");
      put_str("u8 q : -5\n");
      put_str("u16 n : 65535\n");
      put_str("u32 n : 1.5\n");
      put_str("u64 big:123\n");
      put_str("f32 r : 3.25\n");
      put_str("f64 r : 1.2.3\n");
      put_str("f64 r : .5\n");
      put_str("string s : 'hello world'\n");
      put_str("string e : ''\n");
      put_str("string s : 42\n");
      put_str("i8 x : 'abc\n");
      put_str("i8 x '\n");
      put_str("int x : 1\n");
      put_str("i8 u8 : 1\n");
      put_str("i8 9x : 1\n");
      put_str("i8 x y 1\n");
      put_str("i8 x : 1 2\n");
      put_str("i8 x :\n");
      put_str(" \t");
      text_q.push_back(CH_CR);
      put_str("\n\ni8 x = 1\ni8 ");
      text_q.push_back(8'h00);
      put_str(" : 1\ni8 x : ");
      text_q.push_back(8'hff);
      put_str("\n");
      send_text(1'b0);
      // last byte flagged mid-line, then line numbering restarts
      put_str("f32 t : 7");
      send_text(1'b1);
      put_str("i8 a : 1\n");
      // full-length line, then a line longer than the limit
      put_str("u16 n : ");
      repeat (LINE_LIMIT - 8) put_str("7");
      put_str("\n");
      repeat (1000) put_str(" ");
      put_str("i8 x : 1\ni8 ");
      repeat (LINE_LIMIT + 6) put_str("a");
      put_str("\n");
      send_text(1'b0);
      put_str("\n");
      send_text(1'b1);
      wait_drained();

      rand_bytes = 0;
      first_lines = sb.lines_out;
      while (rand_bytes < 800 || sb.lines_out - first_lines < 40) begin
         calm = $urandom_range(0, 9) == 0;
         if ($urandom_range(0, 49) == 0)
            wait_drained();
         make_line();
         r = $urandom_range(0, 99);
         if (r < 94 || (r < 97 && text_q.size() == 0)) begin
            put_str("\n");
            rand_bytes += text_q.size();
            send_text(1'b0);
         end else begin
            if (r >= 97)
               put_str("\n");
            rand_bytes += text_q.size();
            send_text(1'b1);
         end
      end
      calm = 1'b0;
      wait_drained();
      req_valid <= 1'b0;
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/tdlc_pkg.sv
design/tdlc_line_eval.sv
design/typed_declaration_line_checker_core.sv
design/tdlc_checker.sv
tb/tb_typed_declaration_line_checker_core.sv
